[src/vflux_pkg.sv]
// shared constants, register indexes and fixed-point helpers for the viscous flux block
package vflux_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_DIRECTION    = 3'd0;
   localparam logic [2:0] REG_VISCOSITY    = 3'd1;
   localparam logic [2:0] REG_CONDUCTIVITY = 3'd2;
   localparam logic [2:0] REG_INV_RE       = 3'd3;
   localparam logic [2:0] REG_INV_GM1      = 3'd4;
   localparam logic [2:0] REG_INV_PR       = 3'd5;

   // flux direction codes, the spare code acts as z
   localparam logic [1:0] DIR_X = 2'd0;
   localparam logic [1:0] DIR_Y = 2'd1;
   localparam logic [1:0] DIR_Z = 2'd2;

   // reset values of the configuration registers
   localparam logic [1:0]         RST_DIRECTION    = DIR_X;
   localparam logic signed [31:0] RST_VISCOSITY    = 32'sd65536;
   localparam logic signed [31:0] RST_CONDUCTIVITY = 32'sd65536;
   localparam logic signed [31:0] RST_INV_RE       = 32'sd65536;
   localparam logic signed [31:0] RST_INV_GM1      = 32'sd163840;
   localparam logic signed [31:0] RST_INV_PR       = 32'sd91022;

   // 2/3 in Q16.16
   localparam logic signed [31:0] NORMAL_SCALE = 32'sd43691;

   // cycles for the coefficient chain to settle after a write or reset
   localparam logic [1:0] SETTLE_CYCLES = 2'd3;

   localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
   localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > Q_MAX) begin
         r = Q_MAX[31:0];
      end else if (v < Q_MIN) begin
         r = Q_MIN[31:0];
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q16.16 product rounded half up, not clamped
   function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      p = p + 64'sd32768;
      return p[63:16];
   endfunction

   // Q16.16 product rounded half up and clamped
   function automatic logic signed [31:0] qmul_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
      return sat64(64'(qmul(a, b)));
   endfunction

endpackage

[src/viscous_flux_3d.sv]
// viscous flux of 3-d navier-stokes: coefficient chain and four-stage point pipeline
//
// A grid point word enters on req_* when start is high and busy is low; one
// point may enter in every cycle while busy is low. Its flux word leaves on rsp_*
// from the stage 4 register, marked by rsp_valid for a single cycle; the receiver
// cannot stall, so the pipeline never holds and throughput is one point per clock
// while busy is low. Stages: directional stress sums, stress and heat-flux products
// (four multipliers), velocity-times-stress products (three multipliers), energy
// sum and clamp. Configuration is written through csr_we/csr_index/csr_wdata;
// the user must write it only while no points are in flight, and the block itself
// does not enforce this. The coefficients mu/Re, 2/3 mu/Re and kappa/(Re(gamma-1)Pr)
// are formed by a registered chain of three multiplies; busy stays high after each
// write and after reset while that chain settles, so points flow at one per clock
// except for those settle gaps.
// Reset (synchronous, active high) restores the register defaults, empties
// the pipeline and holds busy high through the settle time.
module viscous_flux_3d (
   input  logic               clock,
   input  logic               reset,
   // point channel
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_vel_u,
   input  logic signed [31:0] req_vel_v,
   input  logic signed [31:0] req_vel_w,
   input  logic signed [31:0] req_du_dx,
   input  logic signed [31:0] req_dv_dy,
   input  logic signed [31:0] req_dw_dz,
   input  logic signed [31:0] req_cross_first_a,
   input  logic signed [31:0] req_cross_first_b,
   input  logic signed [31:0] req_cross_second_a,
   input  logic signed [31:0] req_cross_second_b,
   input  logic signed [31:0] req_temp_gradient,
   input  logic               req_last_point,
   // flux channel
   output logic               rsp_valid,
   output logic               rsp_mass_flux,
   output logic signed [31:0] rsp_momentum_flux_x,
   output logic signed [31:0] rsp_momentum_flux_y,
   output logic signed [31:0] rsp_momentum_flux_z,
   output logic signed [31:0] rsp_energy_flux,
   output logic               rsp_last_out,
   // configuration port
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   // configuration registers
   logic [1:0]         dir_ff;
   logic signed [31:0] mu_ff, kappa_ff, inv_re_ff, inv_gm1_ff, inv_pr_ff;
   logic [1:0]         settle_ff, settle_in;

   // coefficient chain
   logic signed [31:0] m_ff, n_ff, kr_ff, kg_ff, k_ff;

   // stage 1: stress sums
   logic               s1_valid_ff;
   logic signed [31:0] s1_nsum_ff, s1_sh1_ff, s1_sh2_ff;
   logic signed [31:0] s1_u_ff, s1_v_ff, s1_w_ff, s1_tg_ff;
   logic               s1_last_ff;
   logic signed [31:0] nsum_in, sh1_in, sh2_in;

   // stage 2: stresses and heat flux
   logic               s2_valid_ff;
   logic signed [31:0] s2_tx_ff, s2_ty_ff, s2_tz_ff;
   logic signed [47:0] s2_q_ff;
   logic signed [31:0] s2_u_ff, s2_v_ff, s2_w_ff;
   logic               s2_last_ff;
   logic signed [31:0] tn_in, t1_in, t2_in;
   logic signed [31:0] tx_in, ty_in, tz_in;

   // stage 3: velocity-stress products
   logic               s3_valid_ff;
   logic signed [47:0] s3_pu_ff, s3_pv_ff, s3_pw_ff, s3_q_ff;
   logic signed [31:0] s3_tx_ff, s3_ty_ff, s3_tz_ff;
   logic               s3_last_ff;

   // stage 4: output word
   logic               s4_valid_ff;
   logic signed [31:0] s4_tx_ff, s4_ty_ff, s4_tz_ff, s4_e_ff;
   logic               s4_last_ff;
   logic signed [63:0] e_sum;

   logic               accept;

   assign busy   = reset | (settle_ff != 2'd0);
   assign accept = start & ~busy;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff     <= vflux_pkg::RST_DIRECTION;
         mu_ff      <= vflux_pkg::RST_VISCOSITY;
         kappa_ff   <= vflux_pkg::RST_CONDUCTIVITY;
         inv_re_ff  <= vflux_pkg::RST_INV_RE;
         inv_gm1_ff <= vflux_pkg::RST_INV_GM1;
         inv_pr_ff  <= vflux_pkg::RST_INV_PR;
      end else if (csr_we) begin
         unique case (csr_index)
            vflux_pkg::REG_DIRECTION:    dir_ff     <= csr_wdata[1:0];
            vflux_pkg::REG_VISCOSITY:    mu_ff      <= csr_wdata;
            vflux_pkg::REG_CONDUCTIVITY: kappa_ff   <= csr_wdata;
            vflux_pkg::REG_INV_RE:       inv_re_ff  <= csr_wdata;
            vflux_pkg::REG_INV_GM1:      inv_gm1_ff <= csr_wdata;
            vflux_pkg::REG_INV_PR:       inv_pr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // settle counter, reloaded on every write
   always_comb begin
      if (csr_we) begin
         settle_in = vflux_pkg::SETTLE_CYCLES;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= vflux_pkg::SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   // coefficient chain, one multiply per register
   always_ff @(posedge clock) begin
      m_ff  <= vflux_pkg::qmul_sat(mu_ff, inv_re_ff);
      kr_ff <= vflux_pkg::qmul_sat(kappa_ff, inv_re_ff);
      n_ff  <= vflux_pkg::qmul_sat(m_ff, vflux_pkg::NORMAL_SCALE);
      kg_ff <= vflux_pkg::qmul_sat(kr_ff, inv_gm1_ff);
      k_ff  <= vflux_pkg::qmul_sat(kg_ff, inv_pr_ff);
   end

   // stage 1: normal sum for the direction and the two shear pair sums
   always_comb begin
      case (dir_ff)
         vflux_pkg::DIR_X: begin
            nsum_in = vflux_pkg::sat64(64'(req_du_dx) + 64'(req_du_dx)
                                       - 64'(req_dv_dy) - 64'(req_dw_dz));
         end
         vflux_pkg::DIR_Y: begin
            nsum_in = vflux_pkg::sat64(64'(req_dv_dy) + 64'(req_dv_dy)
                                       - 64'(req_du_dx) - 64'(req_dw_dz));
         end
         default: begin
            nsum_in = vflux_pkg::sat64(64'(req_dw_dz) + 64'(req_dw_dz)
                                       - 64'(req_du_dx) - 64'(req_dv_dy));
         end
      endcase
      sh1_in = vflux_pkg::sat64(64'(req_cross_first_a) + 64'(req_cross_first_b));
      sh2_in = vflux_pkg::sat64(64'(req_cross_second_a) + 64'(req_cross_second_b));
   end

   always_ff @(posedge clock) begin
      s1_nsum_ff <= nsum_in;
      s1_sh1_ff  <= sh1_in;
      s1_sh2_ff  <= sh2_in;
      s1_u_ff    <= req_vel_u;
      s1_v_ff    <= req_vel_v;
      s1_w_ff    <= req_vel_w;
      s1_tg_ff   <= req_temp_gradient;
      s1_last_ff <= req_last_point;
   end

   // stage 2: stresses, placed by direction, and rounded heat flux
   always_comb begin
      tn_in = vflux_pkg::qmul_sat(n_ff, s1_nsum_ff);
      t1_in = vflux_pkg::qmul_sat(m_ff, s1_sh1_ff);
      t2_in = vflux_pkg::qmul_sat(m_ff, s1_sh2_ff);
      case (dir_ff)
         vflux_pkg::DIR_X: begin
            tx_in = tn_in;
            ty_in = t1_in;
            tz_in = t2_in;
         end
         vflux_pkg::DIR_Y: begin
            tx_in = t1_in;
            ty_in = tn_in;
            tz_in = t2_in;
         end
         default: begin
            tx_in = t1_in;
            ty_in = t2_in;
            tz_in = tn_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      s2_tx_ff   <= tx_in;
      s2_ty_ff   <= ty_in;
      s2_tz_ff   <= tz_in;
      s2_q_ff    <= vflux_pkg::qmul(k_ff, s1_tg_ff);
      s2_u_ff    <= s1_u_ff;
      s2_v_ff    <= s1_v_ff;
      s2_w_ff    <= s1_w_ff;
      s2_last_ff <= s1_last_ff;
   end

   // stage 3: velocity times stress, rounded only
   always_ff @(posedge clock) begin
      s3_pu_ff   <= vflux_pkg::qmul(s2_u_ff, s2_tx_ff);
      s3_pv_ff   <= vflux_pkg::qmul(s2_v_ff, s2_ty_ff);
      s3_pw_ff   <= vflux_pkg::qmul(s2_w_ff, s2_tz_ff);
      s3_q_ff    <= s2_q_ff;
      s3_tx_ff   <= s2_tx_ff;
      s3_ty_ff   <= s2_ty_ff;
      s3_tz_ff   <= s2_tz_ff;
      s3_last_ff <= s2_last_ff;
   end

   // stage 4: energy sum, clamped once
   assign e_sum = 64'(s3_pu_ff) + 64'(s3_pv_ff) + 64'(s3_pw_ff) + 64'(s3_q_ff);

   always_ff @(posedge clock) begin
      s4_tx_ff   <= s3_tx_ff;
      s4_ty_ff   <= s3_ty_ff;
      s4_tz_ff   <= s3_tz_ff;
      s4_e_ff    <= vflux_pkg::sat64(e_sum);
      s4_last_ff <= s3_last_ff;
   end

   // valid bits travel with the word
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // flux word
   assign rsp_valid           = s4_valid_ff;
   assign rsp_mass_flux       = 1'b0;
   assign rsp_momentum_flux_x = s4_tx_ff;
   assign rsp_momentum_flux_y = s4_ty_ff;
   assign rsp_momentum_flux_z = s4_tz_ff;
   assign rsp_energy_flux     = s4_e_ff;
   assign rsp_last_out        = s4_last_ff;

endmodule

[tb/tb_viscous_flux_3d.sv]
// self-checking testbench for the viscous flux block: directed and random point words
`timescale 1ns / 1ps

module tb_viscous_flux_3d;

   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          TAIL_CYCLES   = 12;
   localparam int          RAND_PHASES   = 8;
   localparam int          PHASE_POINTS  = 110;
   localparam int          STREAM_POINTS = 150;
   localparam int          MAX_PRINTS    = 100;
   localparam logic [1:0]  DIR_SPARE     = 2'd3;
   localparam logic [2:0]  REG_SPARE_A   = 3'd6;
   localparam logic [2:0]  REG_SPARE_B   = 3'd7;
   localparam logic [31:0] Q_TOP         = 32'h7fff_ffff;
   localparam logic [31:0] Q_BOTTOM      = 32'h8000_0000;
   localparam logic [31:0] Q_ONE         = 32'h0001_0000;

   typedef struct {
      logic signed [31:0] vel_u, vel_v, vel_w;
      logic signed [31:0] du_dx, dv_dy, dw_dz;
      logic signed [31:0] first_a, first_b, second_a, second_b;
      logic signed [31:0] temp_grad;
      logic               last;
   } point_type;

   typedef struct {
      logic               mass;
      logic signed [31:0] mom_x, mom_y, mom_z;
      logic signed [31:0] energy;
      logic               last;
   } flux_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_vel_u, req_vel_v, req_vel_w;
   logic signed [31:0] req_du_dx, req_dv_dy, req_dw_dz;
   logic signed [31:0] req_cross_first_a, req_cross_first_b;
   logic signed [31:0] req_cross_second_a, req_cross_second_b;
   logic signed [31:0] req_temp_gradient;
   logic               req_last_point;
   logic               rsp_valid;
   logic               rsp_mass_flux;
   logic signed [31:0] rsp_momentum_flux_x, rsp_momentum_flux_y, rsp_momentum_flux_z;
   logic signed [31:0] rsp_energy_flux;
   logic               rsp_last_out;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   // shadow copy of the configuration registers
   logic [1:0]         cfg_dir;
   logic signed [31:0] cfg_mu, cfg_kappa, cfg_inv_re, cfg_inv_gm1, cfg_inv_pr;

   flux_type pending_flux[$];
   int       points_sent;
   int       flux_checked;
   int       csr_writes;
   int       err_count;
   int       cycle_count;
   int       dir_hits[4];

   viscous_flux_3d u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_vel_u           (req_vel_u),
      .req_vel_v           (req_vel_v),
      .req_vel_w           (req_vel_w),
      .req_du_dx           (req_du_dx),
      .req_dv_dy           (req_dv_dy),
      .req_dw_dz           (req_dw_dz),
      .req_cross_first_a   (req_cross_first_a),
      .req_cross_first_b   (req_cross_first_b),
      .req_cross_second_a  (req_cross_second_a),
      .req_cross_second_b  (req_cross_second_b),
      .req_temp_gradient   (req_temp_gradient),
      .req_last_point      (req_last_point),
      .rsp_valid           (rsp_valid),
      .rsp_mass_flux       (rsp_mass_flux),
      .rsp_momentum_flux_x (rsp_momentum_flux_x),
      .rsp_momentum_flux_y (rsp_momentum_flux_y),
      .rsp_momentum_flux_z (rsp_momentum_flux_z),
      .rsp_energy_flux     (rsp_energy_flux),
      .rsp_last_out        (rsp_last_out),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // clock
   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d flux words still pending",
                  cycle_count, pending_flux.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // q16.16 product rounded half up, kept wide
   function automatic logic signed [63:0] round_q(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      return (a * b + 64'sd32768) >>> 16;
   endfunction

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] clamp_q(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = Q_TOP;
      end else if (v < -64'sd2147483648) begin
         r = Q_BOTTOM;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] mul_clamp(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      return clamp_q(round_q(a, b));
   endfunction

   // expected flux word for one point under the current configuration
   function automatic flux_type predict_flux(input point_type p);
      flux_type           f;
      logic signed [31:0] m, n, k, shear_a, shear_b, tx, ty, tz;
      logic signed [63:0] ux, vy, wz, fa, fb, sa, sb, sum_e;
      ux = p.du_dx;
      vy = p.dv_dy;
      wz = p.dw_dz;
      fa = p.first_a;
      fb = p.first_b;
      sa = p.second_a;
      sb = p.second_b;
      // coefficient chain
      m = mul_clamp(cfg_mu, cfg_inv_re);
      n = mul_clamp(m, vflux_pkg::NORMAL_SCALE);
      k = mul_clamp(mul_clamp(mul_clamp(cfg_kappa, cfg_inv_re), cfg_inv_gm1), cfg_inv_pr);
      shear_a = mul_clamp(m, clamp_q(fa + fb));
      shear_b = mul_clamp(m, clamp_q(sa + sb));
      // normal stress goes to the flux direction, spare code acts as z
      case (cfg_dir)
         vflux_pkg::DIR_X: begin
            tx = mul_clamp(n, clamp_q(64'sd2 * ux - vy - wz));
            ty = shear_a;
            tz = shear_b;
         end
         vflux_pkg::DIR_Y: begin
            tx = shear_a;
            ty = mul_clamp(n, clamp_q(64'sd2 * vy - ux - wz));
            tz = shear_b;
         end
         default: begin
            tx = shear_a;
            ty = shear_b;
            tz = mul_clamp(n, clamp_q(64'sd2 * wz - ux - vy));
         end
      endcase
      // energy: products unclamped, one clamp on the sum
      sum_e = round_q(p.vel_u, tx) + round_q(p.vel_v, ty) + round_q(p.vel_w, tz)
            + round_q(k, p.temp_grad);
      f.mass   = 1'b0;
      f.mom_x  = tx;
      f.mom_y  = ty;
      f.mom_z  = tz;
      f.energy = clamp_q(sum_e);
      f.last   = p.last;
      return f;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (err_count < MAX_PRINTS) begin
         $display("mismatch at flux word %0d: %s got %h want %h",
                  flux_checked, what, got, want);
      end
      err_count++;
   endtask

   // capture accepted points and check each flux word against the oldest prediction
   always @(posedge clock) begin : flux_monitor
      point_type seen;
      flux_type  want;
      if (!reset && start === 1'b1 && busy === 1'b0) begin
         seen.vel_u     = req_vel_u;
         seen.vel_v     = req_vel_v;
         seen.vel_w     = req_vel_w;
         seen.du_dx     = req_du_dx;
         seen.dv_dy     = req_dv_dy;
         seen.dw_dz     = req_dw_dz;
         seen.first_a   = req_cross_first_a;
         seen.first_b   = req_cross_first_b;
         seen.second_a  = req_cross_second_a;
         seen.second_b  = req_cross_second_b;
         seen.temp_grad = req_temp_gradient;
         seen.last      = req_last_point;
         pending_flux.push_back(predict_flux(seen));
         points_sent++;
         dir_hits[cfg_dir]++;
      end
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_flux.size() == 0) begin
            report_mismatch("flux word with none pending", rsp_energy_flux, 32'h0);
         end else begin
            want = pending_flux.pop_front();
            if (rsp_mass_flux !== want.mass)
               report_mismatch("mass_flux", 32'(rsp_mass_flux), 32'(want.mass));
            if (rsp_momentum_flux_x !== want.mom_x)
               report_mismatch("momentum_flux_x", rsp_momentum_flux_x, want.mom_x);
            if (rsp_momentum_flux_y !== want.mom_y)
               report_mismatch("momentum_flux_y", rsp_momentum_flux_y, want.mom_y);
            if (rsp_momentum_flux_z !== want.mom_z)
               report_mismatch("momentum_flux_z", rsp_momentum_flux_z, want.mom_z);
            if (rsp_energy_flux !== want.energy)
               report_mismatch("energy_flux", rsp_energy_flux, want.energy);
            if (rsp_last_out !== want.last)
               report_mismatch("last_out", 32'(rsp_last_out), 32'(want.last));
         end
         flux_checked++;
      end
   end

   // drive one point word and hold it until the block takes it
   task automatic send_point(input point_type p);
      @(negedge clock);
      start              <= 1'b1;
      req_vel_u          <= p.vel_u;
      req_vel_v          <= p.vel_v;
      req_vel_w          <= p.vel_w;
      req_du_dx          <= p.du_dx;
      req_dv_dy          <= p.dv_dy;
      req_dw_dz          <= p.dw_dz;
      req_cross_first_a  <= p.first_a;
      req_cross_first_b  <= p.first_b;
      req_cross_second_a <= p.second_a;
      req_cross_second_b <= p.second_b;
      req_temp_gradient  <= p.temp_grad;
      req_last_point     <= p.last;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // stop sending and wait for every pending flux word, then let the pipe settle
   task automatic wait_drained;
      idle_cycles(1);
      while (pending_flux.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      start     <= 1'b0;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         vflux_pkg::REG_DIRECTION:    cfg_dir     = data[1:0];
         vflux_pkg::REG_VISCOSITY:    cfg_mu      = data;
         vflux_pkg::REG_CONDUCTIVITY: cfg_kappa   = data;
         vflux_pkg::REG_INV_RE:       cfg_inv_re  = data;
         vflux_pkg::REG_INV_GM1:      cfg_inv_gm1 = data;
         vflux_pkg::REG_INV_PR:       cfg_inv_pr  = data;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_config(input logic [31:0] dir, input logic [31:0] mu,
                              input logic [31:0] kappa, input logic [31:0] inv_re,
                              input logic [31:0] inv_gm1, input logic [31:0] inv_pr);
      csr_write(vflux_pkg::REG_DIRECTION, dir);
      csr_write(vflux_pkg::REG_VISCOSITY, mu);
      csr_write(vflux_pkg::REG_CONDUCTIVITY, kappa);
      csr_write(vflux_pkg::REG_INV_RE, inv_re);
      csr_write(vflux_pkg::REG_INV_GM1, inv_gm1);
      csr_write(vflux_pkg::REG_INV_PR, inv_pr);
   endtask

   function automatic logic [31:0] pick_extreme;
      logic [31:0] r;
      case ($urandom_range(0, 4))
         0:       r = Q_TOP;
         1:       r = Q_BOTTOM;
         2:       r = 32'h0;
         3:       r = 32'hffff_ffff;
         default: r = Q_ONE;
      endcase
      return r;
   endfunction

   // field value: mostly small or full range, some extremes
   function automatic logic [31:0] rand_field(input bit small_only);
      logic [31:0] r;
      if (small_only) begin
         r = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: r = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            4, 5, 6, 7: r = $urandom;
            8:          r = pick_extreme();
            default:    r = 32'h0;
         endcase
      end
      return r;
   endfunction

   function automatic point_type rand_point(input bit small_only);
      point_type p;
      p.vel_u     = rand_field(small_only);
      p.vel_v     = rand_field(small_only);
      p.vel_w     = rand_field(small_only);
      p.du_dx     = rand_field(small_only);
      p.dv_dy     = rand_field(small_only);
      p.dw_dz     = rand_field(small_only);
      p.first_a   = rand_field(small_only);
      p.first_b   = rand_field(small_only);
      p.second_a  = rand_field(small_only);
      p.second_b  = rand_field(small_only);
      p.temp_grad = rand_field(small_only);
      p.last      = ($urandom_range(0, 7) == 0);
      return p;
   endfunction

   function automatic point_type fill_point(input logic [31:0] val, input logic last);
      point_type p;
      p.vel_u     = val;
      p.vel_v     = val;
      p.vel_w     = val;
      p.du_dx     = val;
      p.dv_dy     = val;
      p.dw_dz     = val;
      p.first_a   = val;
      p.first_b   = val;
      p.second_a  = val;
      p.second_b  = val;
      p.temp_grad = val;
      p.last      = last;
      return p;
   endfunction

   // coefficient value: mostly physical sizes, some full range and extremes
   function automatic logic [31:0] rand_coef;
      logic [31:0] r;
      case ($urandom_range(0, 5))
         0, 1, 2: r = $urandom_range(0, 32'h0003_0000);
         3:       r = $urandom;
         4:       r = pick_extreme();
         default: r = 32'h0 - $urandom_range(0, 32'h0002_0000);
      endcase
      return r;
   endfunction

   // reset coefficients with field extremes and small values
   task automatic test_default_coefficients;
      send_point(fill_point(32'h0, 1'b0));
      send_point(rand_point(1'b1));
      send_point(fill_point(Q_TOP, 1'b1));
      send_point(fill_point(Q_BOTTOM, 1'b0));
   endtask

   // each direction code, the spare one included
   task automatic test_each_direction;
      for (int d = 0; d < 4; d++) begin
         wait_drained();
         csr_write(vflux_pkg::REG_DIRECTION, 32'(d));
         send_point(rand_point(1'b1));
         send_point(rand_point(1'b0));
      end
   endtask

   // coefficients at the top and bottom of the range drive the coefficient clamps
   task automatic test_coefficient_extremes;
      wait_drained();
      load_config(32'(vflux_pkg::DIR_X), Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP);
      send_point(fill_point(Q_TOP, 1'b0));
      wait_drained();
      load_config(32'(vflux_pkg::DIR_Y), Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM);
      send_point(fill_point(Q_BOTTOM, 1'b1));
      send_point(rand_point(1'b0));
   endtask

   // writes to unused indexes leave the configuration alone
   task automatic test_ignored_index;
      wait_drained();
      load_config(32'(DIR_SPARE), vflux_pkg::RST_VISCOSITY, vflux_pkg::RST_CONDUCTIVITY,
                  vflux_pkg::RST_INV_RE, vflux_pkg::RST_INV_GM1, vflux_pkg::RST_INV_PR);
      csr_write(REG_SPARE_A, $urandom);
      csr_write(REG_SPARE_B, $urandom);
      send_point(rand_point(1'b1));
      send_point(rand_point(1'b0));
   endtask

   // random phases, each with its own configuration and random sender gaps
   task automatic test_random_phases;
      int calm;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         wait_drained();
         case (ph)
            1:       load_config($urandom, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP);
            2:       load_config($urandom, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM,
                                 Q_BOTTOM);
            default: load_config($urandom, rand_coef(), rand_coef(), rand_coef(),
                                 rand_coef(), rand_coef());
         endcase
         calm = 0;
         for (int i = 0; i < PHASE_POINTS; i++) begin
            // halfway through even phases the sender holds off until the pipe is empty
            if (i == PHASE_POINTS / 2 && ph % 2 == 0) wait_drained();
            if (calm > 0) begin
               calm--;
            end else if ($urandom_range(0, 15) == 0) begin
               calm = $urandom_range(10, 40);
            end else if ($urandom_range(0, 2) == 0) begin
               idle_cycles($urandom_range(1, 16));
            end
            send_point(rand_point($urandom_range(0, 1) == 0));
         end
      end
   endtask

   // back-to-back points with no gaps at all
   task automatic test_streaming;
      wait_drained();
      load_config($urandom, rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                  rand_coef());
      for (int i = 0; i < STREAM_POINTS; i++) begin
         send_point(rand_point($urandom_range(0, 1) == 0));
      end
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      start              = 1'b0;
      req_vel_u          = '0;
      req_vel_v          = '0;
      req_vel_w          = '0;
      req_du_dx          = '0;
      req_dv_dy          = '0;
      req_dw_dz          = '0;
      req_cross_first_a  = '0;
      req_cross_first_b  = '0;
      req_cross_second_a = '0;
      req_cross_second_b = '0;
      req_temp_gradient  = '0;
      req_last_point     = 1'b0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      cfg_dir            = vflux_pkg::RST_DIRECTION;
      cfg_mu             = vflux_pkg::RST_VISCOSITY;
      cfg_kappa          = vflux_pkg::RST_CONDUCTIVITY;
      cfg_inv_re         = vflux_pkg::RST_INV_RE;
      cfg_inv_gm1        = vflux_pkg::RST_INV_GM1;
      cfg_inv_pr         = vflux_pkg::RST_INV_PR;
      points_sent        = 0;
      flux_checked       = 0;
      csr_writes         = 0;
      err_count          = 0;
      cycle_count        = 0;
      for (int d = 0; d < 4; d++) dir_hits[d] = 0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_coefficients();
      test_each_direction();
      test_coefficient_extremes();
      test_ignored_index();
      test_random_phases();
      test_streaming();
      wait_drained();

      if (pending_flux.size() != 0)
         report_mismatch("flux words never returned", pending_flux.size(), 32'h0);

      $display("sent %0d points, checked %0d flux words, %0d register writes",
               points_sent, flux_checked, csr_writes);
      $display("points per direction x %0d y %0d z %0d spare %0d, %0d mismatches",
               dir_hits[0], dir_hits[1], dir_hits[2], dir_hits[3], err_count);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
